// ===== rtl/core/str_pkg.sv =====
`default_nettype none
package str_pkg;

    localparam int WIN_BYTES  = 8;
    localparam int KEPT_CHARS = 4;
    localparam int LEN_BITS   = 16;

    localparam int CNT_W     = $clog2(WIN_BYTES + 1);
    localparam int WIN_IDX_W = $clog2(WIN_BYTES);
    localparam int KCNT_W    = $clog2(KEPT_CHARS + 2);
    localparam int KIDX_W    = (KEPT_CHARS > 1) ? $clog2(KEPT_CHARS) : 1;
    localparam int MAXLEN_W  = 16;
    localparam int CMP_W     = (LEN_BITS > MAXLEN_W) ? LEN_BITS : MAXLEN_W;

    localparam int NUM_PATS   = 13;
    localparam int PAT_MAX    = 7;
    localparam int BEARER_LEN = 7;
    localparam int RED_LEN    = 10;
    localparam int SEQ_W      = 4;
    localparam int HLEN_W     = 3;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Emission sources.
    localparam logic [1:0] SRC_WIN  = 2'd0;
    localparam logic [1:0] SRC_KEPT = 2'd1;
    localparam logic [1:0] SRC_RED  = 2'd2;

    // Match modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_BEARER = 2'd1;
    localparam logic [1:0] MODE_PREFIX = 2'd2;

    // Pattern check outcomes.
    localparam logic [1:0] ST_FAIL = 2'd0;
    localparam logic [1:0] ST_OPEN = 2'd1;
    localparam logic [1:0] ST_HIT  = 2'd2;

    typedef logic [7:0] byte_t;
    typedef byte_t win_t [WIN_BYTES];

    // Pattern zero is the bearer prefix, compared case-insensitively.
    localparam byte_t PAT_TXT [NUM_PATS][PAT_MAX] = '{
        '{"b", "e", "a", "r", "e", "r", " "},
        '{"s", "k", "-", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"x", "o", "x", "b", "-", 8'h00, 8'h00},
        '{"x", "o", "x", "p", "-", 8'h00, 8'h00},
        '{"g", "h", "p", "_", 8'h00, 8'h00, 8'h00},
        '{"g", "h", "o", "_", 8'h00, 8'h00, 8'h00},
        '{"g", "h", "s", "_", 8'h00, 8'h00, 8'h00},
        '{"g", "h", "u", "_", 8'h00, 8'h00, 8'h00},
        '{"g", "l", "p", "a", "t", "-", 8'h00},
        '{"A", "K", "I", "A", 8'h00, 8'h00, 8'h00},
        '{"p", "y", "p", "i", "-", 8'h00, 8'h00},
        '{"n", "p", "m", "_", 8'h00, 8'h00, 8'h00},
        '{"s", "h", "p", "a", "t", "_", 8'h00}
    };

    localparam logic [HLEN_W-1:0] PAT_LEN [NUM_PATS] = '{
        3'd7, 3'd3, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd4, 3'd5, 3'd4, 3'd6
    };

    localparam byte_t RED_TXT [RED_LEN] = '{
        "[", "R", "E", "D", "A", "C", "T", "E", "D", "]"
    };

    typedef struct packed {
        logic             append;
        logic             emit;
        logic [1:0]       src;
        logic [SEQ_W-1:0] idx;
        logic             drop_one;
        logic             token_step;
        logic             take_bearer;
        logic             latch_hit;
        logic             take_hit;
        logic             close_done;
        logic             set_idle;
        logic             flush;
    } str_cmd_t;

    typedef struct packed {
        logic       pend_zero;
        logic [1:0] mode;
        logic       win0_secret;
        logic       any_open;
        logic       bearer_hit;
        logic       prefix_hit;
        logic       kept_full;
        logic       busy;
        logic       last;
    } str_sts_t;

    function automatic logic secret_char(input byte_t c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "-" || c == "_" || c == "." ||
               c == ":";
    endfunction

    function automatic byte_t to_lower(input byte_t c);
        return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
    endfunction

    function automatic logic [1:0] check_pat(input win_t w, input logic [CNT_W-1:0] cnt,
                                             input int p, input logic frc);
        logic                ok;
        byte_t               c;
        logic [CNT_W:0]      need;
        ok = 1'b1;
        for (int j = 0; j < PAT_MAX; j++) begin
            c = (p == 0) ? to_lower(w[j]) : w[j];
            if ((j < int'(PAT_LEN[p])) && (j < int'(cnt)) && (c != PAT_TXT[p][j])) begin
                ok = 1'b0;
            end
        end
        need = (CNT_W + 1)'(PAT_LEN[p]) + 1'b1;
        if (!ok) begin
            return ST_FAIL;
        end
        if ({1'b0, cnt} < need) begin
            return frc ? ST_FAIL : ST_OPEN;
        end
        return secret_char(w[WIN_IDX_W'(PAT_LEN[p])]) ? ST_HIT : ST_FAIL;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/secret_token_redactor.sv =====
// A request is accepted while idle; each following scan cycle settles one decision on the
// lookahead window, a pass-through byte being emitted in its own scan cycle, while prefix,
// kept-character and marker bursts emit one byte per cycle; a flush state closes the step.
// A plain pass-through byte goes through accept, emit, scan and close before the next request;
// the three truncation dots and a full output queue stall emitting scans, bursts and the flush.
// Synchronous active-low reset empties the window, counters and queue; truncation on, limit 200.
`default_nettype none
module secret_token_redactor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last,
    output logic             m_message_end,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import str_pkg::*;

    str_cmd_t cmd;
    str_sts_t sts;

    // Configuration writes are always taken; the user must issue them only while the block is idle.
    assign cfg_ready = 1'b1;

    // The controller walks the lookahead window one decision per cycle unless output is busy, and
    // sequences the multi-byte bursts (bearer prefix, kept token characters and the redaction marker).
    str_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the window, the pattern matchers, the length limiter and a small
    // output queue, so that results drain while the next request is being worked on.
    str_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_message_end (m_message_end),
        .cmd           (cmd),
        .sts           (sts)
    );

`ifndef SYNTHESIS
    // A byte is only emitted when the result path can take it.
    a_emit_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.busy)
        else $error("emission issued while output path busy");

    // The step is only closed once all truncation dots have been produced.
    a_flush_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> !sts.busy)
        else $error("step closed with output still pending");

    // One request at a time: after an accept the controller is busy scanning.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request accepted before step finished");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/str_ctrl.sv =====
`default_nettype none
module str_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire str_pkg::str_sts_t sts,
    output str_pkg::str_cmd_t      cmd
);
    import str_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PFX   = 3'd2;
    localparam logic [2:0] S_KEPT  = 3'd3;
    localparam logic [2:0] S_RED   = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    localparam logic [1:0] RK_HIT   = 2'd0;
    localparam logic [1:0] RK_CLOSE = 2'd1;
    localparam logic [1:0] RK_END   = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [SEQ_W-1:0] idx_reg, idx_next;
    logic [1:0]       kind_reg, kind_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.append = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                idx_next = '0;
                if (sts.pend_zero) begin
                    if (sts.last && sts.mode == MODE_BEARER) begin
                        kind_next  = RK_END;
                        state_next = sts.kept_full ? S_KEPT : S_RED;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end else if (sts.mode != MODE_IDLE) begin
                    if (sts.win0_secret) begin
                        cmd.token_step = 1'b1;
                    end else if (sts.mode == MODE_BEARER) begin
                        kind_next  = RK_CLOSE;
                        state_next = sts.kept_full ? S_KEPT : S_RED;
                    end else begin
                        cmd.set_idle = 1'b1;
                    end
                end else if (sts.any_open) begin
                    state_next = S_FLUSH;
                end else if (sts.bearer_hit) begin
                    state_next = S_PFX;
                end else if (sts.prefix_hit) begin
                    cmd.latch_hit = 1'b1;
                    kind_next     = RK_HIT;
                    state_next    = S_RED;
                end else if (!sts.busy) begin
                    cmd.emit     = 1'b1;
                    cmd.src      = SRC_WIN;
                    cmd.idx      = '0;
                    cmd.drop_one = 1'b1;
                end
            end
            S_PFX: begin
                if (!sts.busy) begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_WIN;
                    if (idx_reg == SEQ_W'(BEARER_LEN - 1)) begin
                        cmd.take_bearer = 1'b1;
                        state_next      = S_SCAN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_KEPT: begin
                if (!sts.busy) begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_KEPT;
                    if (idx_reg == SEQ_W'(KEPT_CHARS - 1)) begin
                        idx_next   = '0;
                        state_next = S_RED;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_RED: begin
                if (!sts.busy) begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_RED;
                    if (idx_reg == SEQ_W'(RED_LEN - 1)) begin
                        idx_next = '0;
                        case (kind_reg)
                            RK_HIT: begin
                                cmd.take_hit = 1'b1;
                                state_next   = S_SCAN;
                            end
                            RK_CLOSE: begin
                                cmd.close_done = 1'b1;
                                state_next     = S_SCAN;
                            end
                            RK_END: begin
                                cmd.close_done = 1'b1;
                                state_next     = S_FLUSH;
                            end
                            default: begin
                                state_next = S_SCAN;
                            end
                        endcase
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!sts.busy) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            kind_reg  <= RK_HIT;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            kind_reg  <= kind_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/str_dp.sv =====
`default_nettype none
module str_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_last_byte,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_run_last,
    output logic                   m_message_end,
    input  wire str_pkg::str_cmd_t cmd,
    output str_pkg::str_sts_t      sts
);
    import str_pkg::*;

    localparam int FDEPTH = 4;
    localparam int FPTR_W = $clog2(FDEPTH);
    localparam int FCNT_W = $clog2(FDEPTH + 1);

    typedef logic [9:0] res_t;

    win_t                 win_reg, win_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           mode_reg, mode_next;
    byte_t                kept_reg [KEPT_CHARS];
    byte_t                kept_next [KEPT_CHARS];
    logic [KCNT_W-1:0]    kcnt_reg, kcnt_next;
    logic [LEN_BITS-1:0]  emitted_reg, emitted_next;
    logic                 trunc_reg, trunc_next;
    logic                 te_reg, te_next;
    logic [MAXLEN_W-1:0]  maxlen_reg, maxlen_next;
    logic                 last_reg, last_next;
    logic [HLEN_W-1:0]    hitlen_reg, hitlen_next;
    logic [1:0]           dots_reg, dots_next;
    logic                 hold_valid_reg, hold_valid_next;
    byte_t                hold_byte_reg, hold_byte_next;
    logic                 hold_end_reg, hold_end_next;
    res_t                 fifo_reg [FDEPTH];
    logic [FPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]    fcnt_reg, fcnt_next;

    logic [1:0]           st [NUM_PATS];
    logic                 frc;
    logic                 any_open;
    logic                 pfx_hit;
    logic [HLEN_W-1:0]    hit_len;
    logic                 fifo_full;
    logic                 can_produce;
    logic                 busy;
    byte_t                emit_byte;
    logic                 prod;
    byte_t                prod_byte;
    logic                 prod_end;
    logic                 push;
    res_t                 push_data;
    logic                 pop;
    logic [CNT_W-1:0]     drop_n;
    logic [CNT_W:0]       src_pos;

    assign frc = last_reg | (cnt_reg >= CNT_W'(WIN_BYTES));

    always_comb begin
        any_open = 1'b0;
        pfx_hit  = 1'b0;
        hit_len  = '0;
        for (int p = 0; p < NUM_PATS; p++) begin
            st[p] = check_pat(win_reg, cnt_reg, p, frc);
            if (st[p] == ST_OPEN) begin
                any_open = 1'b1;
            end
        end
        for (int p = NUM_PATS - 1; p >= 1; p--) begin
            if (st[p] == ST_HIT) begin
                pfx_hit = 1'b1;
                hit_len = PAT_LEN[p];
            end
        end
    end

    assign fifo_full   = (fcnt_reg == FCNT_W'(FDEPTH));
    assign can_produce = !hold_valid_reg || !fifo_full;
    assign busy        = (dots_reg != 2'd0) || !can_produce;
    assign pop         = m_valid && m_ready;

    always_comb begin
        case (cmd.src)
            SRC_WIN:  emit_byte = win_reg[cmd.idx[WIN_IDX_W-1:0]];
            SRC_KEPT: emit_byte = kept_reg[cmd.idx[KIDX_W-1:0]];
            SRC_RED:  emit_byte = (cmd.idx < SEQ_W'(RED_LEN)) ? RED_TXT[cmd.idx] : 8'h00;
            default:  emit_byte = 8'h00;
        endcase
    end

    always_comb begin
        win_next        = win_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        kept_next       = kept_reg;
        kcnt_next       = kcnt_reg;
        emitted_next    = emitted_reg;
        trunc_next      = trunc_reg;
        te_next         = te_reg;
        maxlen_next     = maxlen_reg;
        last_next       = last_reg;
        hitlen_next     = hitlen_reg;
        dots_next       = dots_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_end_next   = hold_end_reg;
        prod            = 1'b0;
        prod_byte       = DOT_CHAR;
        prod_end        = 1'b0;
        push            = 1'b0;
        push_data       = '0;
        drop_n          = '0;
        src_pos         = '0;

        if (cfg_valid) begin
            if (cfg_index == 1'b0) begin
                te_next = cfg_data[0];
            end else begin
                maxlen_next = cfg_data;
            end
        end

        if (cmd.append) begin
            last_next = s_last_byte;
            if (cnt_reg < CNT_W'(WIN_BYTES)) begin
                win_next[cnt_reg[WIN_IDX_W-1:0]] = s_data_byte;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        // Trailing dots of a truncation drain ahead of anything else.
        if (dots_reg != 2'd0 && can_produce) begin
            prod      = 1'b1;
            prod_byte = DOT_CHAR;
            prod_end  = (dots_reg == 2'd1);
            dots_next = dots_reg - 1'b1;
        end

        if (cmd.emit && !trunc_reg) begin
            if (te_reg && (CMP_W'(emitted_reg) >= CMP_W'(maxlen_reg))) begin
                prod       = 1'b1;
                prod_byte  = DOT_CHAR;
                prod_end   = 1'b0;
                dots_next  = 2'd2;
                trunc_next = 1'b1;
            end else begin
                prod      = 1'b1;
                prod_byte = emit_byte;
                prod_end  = 1'b0;
                if (emitted_reg != '1) begin
                    emitted_next = emitted_reg + 1'b1;
                end
            end
        end

        if (prod) begin
            if (hold_valid_reg) begin
                push      = 1'b1;
                push_data = {hold_byte_reg, 1'b0, hold_end_reg};
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = prod_byte;
            hold_end_next   = prod_end;
        end

        if (cmd.token_step) begin
            if (mode_reg == MODE_BEARER) begin
                if (kcnt_reg < KCNT_W'(KEPT_CHARS)) begin
                    kept_next[kcnt_reg[KIDX_W-1:0]] = win_reg[0];
                end
                if (kcnt_reg <= KCNT_W'(KEPT_CHARS)) begin
                    kcnt_next = kcnt_reg + 1'b1;
                end
            end
            drop_n = CNT_W'(1);
        end
        if (cmd.drop_one) begin
            drop_n = CNT_W'(1);
        end
        if (cmd.take_bearer) begin
            drop_n    = CNT_W'(BEARER_LEN);
            mode_next = MODE_BEARER;
            kcnt_next = '0;
        end
        if (cmd.latch_hit) begin
            hitlen_next = hit_len;
        end
        if (cmd.take_hit) begin
            drop_n    = CNT_W'(hitlen_reg);
            mode_next = MODE_PREFIX;
        end
        if (cmd.close_done) begin
            kcnt_next = '0;
            mode_next = MODE_IDLE;
        end
        if (cmd.set_idle) begin
            mode_next = MODE_IDLE;
        end

        if (drop_n != '0) begin
            for (int k = 0; k < WIN_BYTES; k++) begin
                src_pos = (CNT_W + 1)'(k) + {1'b0, drop_n};
                if (src_pos < (CNT_W + 1)'(WIN_BYTES)) begin
                    win_next[k] = win_reg[src_pos[WIN_IDX_W-1:0]];
                end
            end
            cnt_next = cnt_reg - drop_n;
        end

        if (cmd.flush) begin
            if (hold_valid_reg) begin
                push      = 1'b1;
                push_data = {hold_byte_reg, 1'b1, hold_end_reg | (last_reg & ~trunc_reg)};
            end
            hold_valid_next = 1'b0;
            if (last_reg) begin
                cnt_next     = '0;
                mode_next    = MODE_IDLE;
                kcnt_next    = '0;
                emitted_next = '0;
                trunc_next   = 1'b0;
            end
        end
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fcnt_next   = fcnt_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    assign m_valid       = (fcnt_reg != '0);
    assign m_out_byte    = fifo_reg[rd_ptr_reg][9:2];
    assign m_run_last    = fifo_reg[rd_ptr_reg][1];
    assign m_message_end = fifo_reg[rd_ptr_reg][0];

    assign sts.pend_zero   = (cnt_reg == '0);
    assign sts.mode        = mode_reg;
    assign sts.win0_secret = secret_char(win_reg[0]);
    assign sts.any_open    = any_open;
    assign sts.bearer_hit  = (st[0] == ST_HIT);
    assign sts.prefix_hit  = pfx_hit;
    assign sts.kept_full   = (kcnt_reg > KCNT_W'(KEPT_CHARS));
    assign sts.busy        = busy;
    assign sts.last        = last_reg;

    always_ff @(posedge aclk) begin
        win_reg       <= win_next;
        kept_reg      <= kept_next;
        hold_byte_reg <= hold_byte_next;
        hold_end_reg  <= hold_end_next;
        hitlen_reg    <= hitlen_next;
        last_reg      <= last_next;
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            mode_reg       <= MODE_IDLE;
            kcnt_reg       <= '0;
            emitted_reg    <= '0;
            trunc_reg      <= 1'b0;
            te_reg         <= 1'b1;
            maxlen_reg     <= 16'd200;
            dots_reg       <= 2'd0;
            hold_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fcnt_reg       <= '0;
        end else begin
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            kcnt_reg       <= kcnt_next;
            emitted_reg    <= emitted_next;
            trunc_reg      <= trunc_next;
            te_reg         <= te_next;
            maxlen_reg     <= maxlen_next;
            dots_reg       <= dots_next;
            hold_valid_reg <= hold_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fcnt_reg       <= fcnt_next;
        end
    end

endmodule
`default_nettype wire
